// ----- hw/rtl/afcn_pkg.sv -----
// ----------------------------------------------------------------------------
// afcn_pkg
// Shared types, character codes and hex helpers of the frame command node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afcn_pkg;

	localparam int BODY_MAX_DEF = 8;

	localparam logic [7:0] ADDR_BCAST = 8'hFF;
	localparam logic [7:0] ADDR_NONE  = 8'h00;

	localparam logic [15:0] VERSION_RST   = 16'h0100;
	localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
	localparam logic [15:0] CFG_BLINK_RST = 16'd1000;
	localparam logic [15:0] ID_BLINK_RST  = 16'd500;

	// Request kinds
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_BOOT   = 2'd2;
	localparam logic [1:0] REQ_BUTTON = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_BOOT_ADDR = 3'd0;
	localparam logic [2:0] REG_VERSION   = 3'd1;
	localparam logic [2:0] REG_TIMEOUT   = 3'd2;
	localparam logic [2:0] REG_CFG_BLINK = 3'd3;
	localparam logic [2:0] REG_ID_BLINK  = 3'd4;

	// Valve requests
	localparam logic [2:0] VALVE_NONE      = 3'd0;
	localparam logic [2:0] VALVE_OPEN_ONE  = 3'd1;
	localparam logic [2:0] VALVE_CLOSE_ONE = 3'd2;
	localparam logic [2:0] VALVE_OPEN_TWO  = 3'd3;
	localparam logic [2:0] VALVE_CLOSE_TWO = 3'd4;

	// Characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_X     = 8'h58;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STAT,
		PH_COLON,
		PH_BODY,
		PH_CKH,
		PH_CKL,
		PH_CR,
		PH_LF
	} phase_t;

	// Reply descriptor handed from the command logic to the reply generator
	typedef struct packed {
		logic            has;
		logic [6:0][7:0] body;
		logic [2:0]      nb;
		logic [7:0]      stagger;
		logic            flash;
		logic [2:0]      valve;
		logic            store;
		logic [7:0]      store_addr;
	} reply_t;

	function automatic logic [7:0] to_hex(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
	endfunction

	function automatic logic hex_ok(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
		       (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] r;
		if (c <= 8'h39) begin
			r = c - 8'h30;
		end else if (c <= 8'h46) begin
			r = c - 8'h37;
		end else begin
			r = c - 8'h57;
		end
		return r[3:0];
	endfunction

	function automatic reply_t mk_reply(input logic [7:0] node, input logic [7:0] cmd,
	                                    input logic [7:0] a0, input logic [7:0] a1);
		reply_t r;
		r         = '0;
		r.has     = 1'b1;
		r.body[0] = to_hex(node[7:4]);
		r.body[1] = to_hex(node[3:0]);
		r.body[2] = cmd;
		r.body[3] = (a0 != 8'd0) ? a0 : a1;
		r.body[4] = a1;
		r.nb      = 3'd3 + {2'd0, (a0 != 8'd0)} + {2'd0, (a1 != 8'd0)};
		return r;
	endfunction

	function automatic reply_t mk_version(input logic [7:0] node, input logic [15:0] ver);
		reply_t r;
		r         = '0;
		r.has     = 1'b1;
		r.body[0] = to_hex(node[7:4]);
		r.body[1] = to_hex(node[3:0]);
		r.body[2] = CH_V;
		r.body[3] = to_hex(ver[15:12]);
		r.body[4] = to_hex(ver[11:8]);
		r.body[5] = to_hex(ver[7:4]);
		r.body[6] = to_hex(ver[3:0]);
		r.nb      = 3'd7;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ascii_frame_command_node_top.sv -----
// ----------------------------------------------------------------------------
// ascii_frame_command_node_top
// Slave node for a colon-framed ASCII command protocol: frame assembly,
// checking, command execution, tick timers and reply serialisation.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+--------------------------
//  in      | in_valid / in_ready                       | req_type, rx_byte
//  out     | out_valid / out_ready                     | has_byte .. stored_address
//  cfg     | cfg_valid / cfg_ready (always ready)      | cfg_index, cfg_data
//
//  A byte, tick, boot or button word runs through the sequencer states IDLE,
//  EMIT and DRAIN. A frame end (len of 3 to 6) adds SCAN and EXEC before EMIT:
//  the body store has one read port, so the checksum adder walks the body one
//  entry a cycle. A reply holds up to twelve words, one a cycle while out_ready
//  stays high. in_ready is low while a word is in work; a stalled out_ready
//  holds the result register and the sequencer. Reset clears all control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ascii_frame_command_node_top import afcn_pkg::*; #(
	parameter int BODY_MAX = BODY_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             has_byte,
	output logic [7:0]       tx_byte,
	output logic             last_byte,
	output logic [7:0]       stagger_slots,
	output logic             led_level,
	output logic             led_flash,
	output logic [2:0]       valve_request,
	output logic             store_request,
	output logic [7:0]       stored_address,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int AW = $clog2(BODY_MAX);
	localparam int CW = $clog2(BODY_MAX + 1);

	// configuration registers
	logic [7:0]  boot_addr_q;
	logic [15:0] version_q, timeout_q, cfg_blink_q, id_blink_q;

	// node state
	state_t      state_q, state_nx;
	logic        in_frame_q;
	logic [CW-1:0] body_cnt_q;
	logic [7:0]  node_q;
	logic        v1_q, v2_q;
	logic        setup_q, sled_q, ident_q, iled_q;
	logic [15:0] elapsed_q, sblink_q, iblink_q;

	// frame scan
	logic [2:0]  len_q, cnt_q, idx_s1;
	logic        dv_s1;
	logic [7:0]  h_q, l_q, cmd_q, arg_q, ckh_q, ckl_q, sum_q;
	logic [7:0]  rdata_q;
	reply_t      desc_q;

	logic        in_acc, cfg_acc, is_end, len_ok, mem_we, gen_start, gen_busy, led;
	logic [15:0] sblink_inc, iblink_inc;
	logic [7:0]  boot_node;

	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign is_end    = in_frame_q && (rx_byte == CH_CR || rx_byte == CH_LF) &&
	                   (body_cnt_q != '0);
	assign len_ok    = (body_cnt_q >= CW'(3)) && (body_cnt_q <= CW'(6));
	assign mem_we    = in_acc && (req_type == REQ_BYTE) && in_frame_q &&
	                   rx_byte != CH_CR && rx_byte != CH_LF && rx_byte != CH_COLON &&
	                   (body_cnt_q < CW'(BODY_MAX));
	assign sblink_inc = sblink_q + 16'd1;
	assign iblink_inc = iblink_q + 16'd1;
	assign boot_node  = (boot_addr_q == ADDR_BCAST) ? ADDR_NONE : boot_addr_q;
	assign led        = setup_q ? sled_q : (ident_q ? iled_q : 1'b0);

	afcn_body_mem #(.DEPTH(BODY_MAX), .AW(AW)) u_body (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (body_cnt_q[AW-1:0]),
		.wdata   (rx_byte),
		.raddr   (AW'(cnt_q)),
		.rdata_q (rdata_q)
	);

	// ---- command decode on the scanned frame --------------------------------
	logic [7:0] addr, uc, ckval;
	logic       frame_ok, has_ck, match, handled, stay;
	reply_t     x_reply;
	logic [7:0] x_node;
	logic       x_v1, x_v2, x_setup_wr, x_setup_val, x_ident_wr, x_ident_val;

	assign addr   = {hex_val(h_q), hex_val(l_q)};
	assign ckval  = {hex_val(ckh_q), hex_val(ckl_q)};
	assign has_ck = (len_q == 3'd5) || (len_q == 3'd6);
	assign uc     = (cmd_q >= 8'h61 && cmd_q <= 8'h7A) ? (cmd_q - 8'd32) : cmd_q;
	assign frame_ok = hex_ok(h_q) && hex_ok(l_q) &&
	                  (!has_ck || (hex_ok(ckh_q) && hex_ok(ckl_q) && sum_q == ckval));
	assign match  = (node_q == ADDR_NONE) ? (addr == ADDR_BCAST) :
	                (addr == node_q || addr == ADDR_BCAST);

	always_comb begin
		x_reply     = '0;
		x_node      = node_q;
		x_v1        = v1_q;
		x_v2        = v2_q;
		x_setup_wr  = 1'b0;
		x_setup_val = 1'b0;
		x_ident_wr  = 1'b0;
		x_ident_val = 1'b0;
		handled     = 1'b0;
		stay        = 1'b0;
		if (frame_ok) begin
			if (uc == CH_N) begin
				if (setup_q) begin
					if (addr == ADDR_NONE || addr == ADDR_BCAST) begin
						x_reply = mk_reply(node_q, CH_E, 8'd0, 8'd0);
					end else begin
						x_node             = addr;
						x_reply            = mk_reply(addr, CH_A, 8'd0, 8'd0);
						x_reply.store      = 1'b1;
						x_reply.store_addr = addr;
						handled            = 1'b1;
					end
				end
			end else if (uc == CH_M) begin
				if (addr == node_q) begin
					x_setup_wr  = 1'b1;
					x_setup_val = 1'b1;
					x_reply     = mk_reply(node_q, CH_A, 8'd0, 8'd0);
					handled     = 1'b1;
					stay        = 1'b1;
				end
			end else if (uc == CH_X) begin
				if (addr == ADDR_BCAST) begin
					if (setup_q) begin
						x_setup_wr = 1'b1;
						handled    = 1'b1;
					end
					if (ident_q) begin
						x_ident_wr = 1'b1;
						handled    = 1'b1;
					end
				end
			end else if (match) begin
				if (uc == CH_W) begin
					if (addr == ADDR_BCAST && node_q != ADDR_NONE) begin
						x_reply         = mk_reply(node_q, CH_W, 8'd0, 8'd0);
						x_reply.stagger = node_q;
						handled         = 1'b1;
					end
				end else if (uc == CH_I || uc == CH_P || uc == CH_O || uc == CH_C ||
				             uc == CH_S || uc == CH_V) begin
					if (addr != ADDR_BCAST) begin
						if (uc == CH_I) begin
							x_ident_wr  = 1'b1;
							x_ident_val = 1'b1;
							x_reply     = mk_reply(node_q, CH_A, 8'd0, 8'd0);
							handled     = 1'b1;
						end else if (uc == CH_P) begin
							x_reply       = mk_reply(node_q, CH_A, 8'd0, 8'd0);
							x_reply.flash = 1'b1;
							handled       = 1'b1;
						end else if (uc == CH_V) begin
							x_reply = mk_version(node_q, version_q);
							handled = 1'b1;
						end else if (uc == CH_S) begin
							if (arg_q == CH_ONE) begin
								x_reply = mk_reply(node_q, CH_R, CH_ONE, v1_q ? CH_O : CH_C);
								handled = 1'b1;
							end else if (arg_q == CH_TWO) begin
								x_reply = mk_reply(node_q, CH_R, CH_TWO, v2_q ? CH_O : CH_C);
								handled = 1'b1;
							end else begin
								x_reply = mk_reply(node_q, CH_E, 8'd0, 8'd0);
							end
							x_reply.flash = 1'b1;
						end else if (arg_q == CH_ONE) begin
							x_v1          = (uc == CH_O);
							x_reply       = mk_reply(node_q, CH_A, 8'd0, 8'd0);
							x_reply.valve = (uc == CH_O) ? VALVE_OPEN_ONE : VALVE_CLOSE_ONE;
							handled       = 1'b1;
						end else if (arg_q == CH_TWO) begin
							x_v2          = (uc == CH_O);
							x_reply       = mk_reply(node_q, CH_A, 8'd0, 8'd0);
							x_reply.valve = (uc == CH_O) ? VALVE_OPEN_TWO : VALVE_CLOSE_TWO;
							handled       = 1'b1;
						end else begin
							x_reply = mk_reply(node_q, CH_E, 8'd0, 8'd0);
						end
					end
				end else if (addr != ADDR_BCAST) begin
					x_reply = mk_reply(node_q, CH_E, 8'd0, 8'd0);
				end
			end
			// any handled command but config entry leaves config mode
			if (handled && setup_q && !stay) begin
				x_setup_wr  = 1'b1;
				x_setup_val = 1'b0;
			end
		end
	end

	// ---- sequencer ----------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nx = (req_type == REQ_BYTE && is_end && len_ok) ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (dv_s1 && idx_s1 == len_q - 3'd1) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC:  state_nx = ST_EMIT;
			ST_EMIT:  state_nx = ST_DRAIN;
			ST_DRAIN: begin
				if (!gen_busy) begin
					state_nx = ST_IDLE;
				end
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		gen_start = (state_q == ST_EMIT);
	end

	// ---- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_addr_q <= 8'd0;
			version_q   <= VERSION_RST;
			timeout_q   <= TIMEOUT_RST;
			cfg_blink_q <= CFG_BLINK_RST;
			id_blink_q  <= ID_BLINK_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_BOOT_ADDR: boot_addr_q <= cfg_data[7:0];
				REG_VERSION:   version_q   <= cfg_data;
				REG_TIMEOUT:   timeout_q   <= cfg_data;
				REG_CFG_BLINK: cfg_blink_q <= cfg_data;
				REG_ID_BLINK:  id_blink_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- node state ---------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
			body_cnt_q <= '0;
			node_q     <= ADDR_NONE;
			v1_q       <= 1'b0;
			v2_q       <= 1'b0;
			setup_q    <= 1'b0;
			elapsed_q  <= 16'd0;
			sblink_q   <= 16'd0;
			sled_q     <= 1'b0;
			ident_q    <= 1'b0;
			iblink_q   <= 16'd0;
			iled_q     <= 1'b0;
			cnt_q      <= 3'd0;
			dv_s1      <= 1'b0;
			desc_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				desc_q <= '0;
				case (req_type)
					REQ_BYTE: begin
						if (!in_frame_q) begin
							if (rx_byte == CH_COLON) begin
								in_frame_q <= 1'b1;
								body_cnt_q <= '0;
							end
						end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
							in_frame_q <= 1'b0;
							body_cnt_q <= '0;
							len_q      <= body_cnt_q[2:0];
							cnt_q      <= 3'd0;
							dv_s1      <= 1'b0;
						end else if (rx_byte == CH_COLON) begin
							// restart: empty the body
							body_cnt_q <= '0;
						end else if (body_cnt_q >= CW'(BODY_MAX)) begin
							// overlong: drop the frame
							in_frame_q <= 1'b0;
							body_cnt_q <= '0;
						end else begin
							body_cnt_q <= body_cnt_q + CW'(1);
						end
					end
					REQ_TICK: begin
						if (setup_q) begin
							if (elapsed_q < timeout_q) begin
								elapsed_q <= elapsed_q + 16'd1;
								if (sblink_inc >= cfg_blink_q) begin
									sblink_q <= 16'd0;
									sled_q   <= !sled_q;
								end else begin
									sblink_q <= sblink_inc;
								end
							end else begin
								setup_q   <= 1'b0;
								elapsed_q <= 16'd0;
								sblink_q  <= 16'd0;
								sled_q    <= 1'b0;
							end
						end else if (ident_q) begin
							if (iblink_inc >= id_blink_q) begin
								iblink_q <= 16'd0;
								iled_q   <= !iled_q;
							end else begin
								iblink_q <= iblink_inc;
							end
						end
					end
					REQ_BOOT: begin
						in_frame_q <= 1'b0;
						body_cnt_q <= '0;
						node_q     <= boot_node;
						v1_q       <= 1'b0;
						v2_q       <= 1'b0;
						setup_q    <= 1'b0;
						elapsed_q  <= 16'd0;
						sblink_q   <= 16'd0;
						sled_q     <= 1'b0;
						ident_q    <= 1'b0;
						iblink_q   <= 16'd0;
						iled_q     <= 1'b0;
						if (boot_node != ADDR_NONE) begin
							desc_q <= mk_reply(boot_node, CH_B, 8'd0, 8'd0);
						end
					end
					REQ_BUTTON: begin
						setup_q   <= 1'b1;
						elapsed_q <= 16'd0;
						sblink_q  <= 16'd0;
						sled_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_SCAN) begin
				// issue one read a cycle; its data lands in the next cycle
				if (cnt_q != len_q) begin
					cnt_q <= cnt_q + 3'd1;
				end
				dv_s1 <= (cnt_q != len_q);
			end
			if (state_q == ST_EXEC) begin
				desc_q <= x_reply;
				node_q <= x_node;
				v1_q   <= x_v1;
				v2_q   <= x_v2;
				if (x_setup_wr) begin
					setup_q   <= x_setup_val;
					elapsed_q <= 16'd0;
					sblink_q  <= 16'd0;
					sled_q    <= 1'b0;
				end
				if (x_ident_wr) begin
					ident_q  <= x_ident_val;
					iblink_q <= 16'd0;
					iled_q   <= 1'b0;
				end
			end
		end
	end

	// scan data path: capture fields and run the checksum adder
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			idx_s1 <= cnt_q;
			if (cnt_q == 3'd0) begin
				sum_q <= 8'd0;
				arg_q <= 8'd0;
			end
			if (dv_s1) begin
				if (idx_s1 == 3'd0) h_q   <= rdata_q;
				if (idx_s1 == 3'd1) l_q   <= rdata_q;
				if (idx_s1 == 3'd2) cmd_q <= rdata_q;
				if (idx_s1 == 3'd3 && (len_q == 3'd4 || len_q == 3'd6)) arg_q <= rdata_q;
				if (has_ck && idx_s1 == len_q - 3'd2) ckh_q <= rdata_q;
				if (has_ck && idx_s1 == len_q - 3'd1) ckl_q <= rdata_q;
				if (idx_s1 < len_q - 3'd2) sum_q <= sum_q + rdata_q;
			end
		end
	end

	afcn_reply_gen u_reply (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (gen_start),
		.desc           (desc_q),
		.led            (led),
		.busy           (gen_busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.has_byte       (has_byte),
		.tx_byte        (tx_byte),
		.last_byte      (last_byte),
		.stagger_slots  (stagger_slots),
		.led_level      (led_level),
		.led_flash      (led_flash),
		.valve_request  (valve_request),
		.store_request  (store_request),
		.stored_address (stored_address)
	);

	// ---- checks -------------------------------------------------------------
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !gen_busy)
		else $error("input taken while a reply is still in flight");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !out_valid)
		else $error("word emitted after the final word of a run");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (len_q >= 3'd3 && len_q <= 3'd6))
		else $error("body scan started with a bad length");

	a_valve_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valve_request != VALVE_NONE |-> last_byte)
		else $error("valve request outside the final word");

endmodule

`default_nettype wire

// ----- hw/rtl/afcn_body_mem.sv -----
// ----------------------------------------------------------------------------
// afcn_body_mem
// Frame body store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afcn_body_mem import afcn_pkg::*; #(
	parameter int DEPTH = BODY_MAX_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata_q
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/afcn_reply_gen.sv -----
// ----------------------------------------------------------------------------
// afcn_reply_gen
// Serialise one reply frame word by word with its running checksum, or a status word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afcn_reply_gen import afcn_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire reply_t     desc,
	input  wire logic       led,
	output logic            busy,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            has_byte,
	output logic [7:0]      tx_byte,
	output logic            last_byte,
	output logic [7:0]      stagger_slots,
	output logic            led_level,
	output logic            led_flash,
	output logic [2:0]      valve_request,
	output logic            store_request,
	output logic [7:0]      stored_address
);

	phase_t     ph_q, ph_nx;
	reply_t     d_q;
	logic [2:0] idx_q;
	logic [7:0] sum_q;
	logic       first_q;
	logic       led_q;
	logic       ld;
	logic [7:0] byte_nx;
	logic       last_nx;
	logic [2:0] last_idx;

	assign ld       = (ph_q != PH_IDLE) && (!out_valid || out_ready);
	assign busy     = (ph_q != PH_IDLE) || out_valid;
	assign last_idx = d_q.nb - 3'd1;

	always_comb begin
		byte_nx = 8'd0;
		last_nx = 1'b0;
		ph_nx   = ph_q;
		case (ph_q)
			PH_STAT: begin
				last_nx = 1'b1;
				ph_nx   = PH_IDLE;
			end
			PH_COLON: begin
				byte_nx = CH_COLON;
				ph_nx   = PH_BODY;
			end
			PH_BODY: begin
				byte_nx = d_q.body[idx_q];
				ph_nx   = (idx_q == last_idx) ? PH_CKH : PH_BODY;
			end
			PH_CKH: begin
				byte_nx = to_hex(sum_q[7:4]);
				ph_nx   = PH_CKL;
			end
			PH_CKL: begin
				byte_nx = to_hex(sum_q[3:0]);
				ph_nx   = PH_CR;
			end
			PH_CR: begin
				byte_nx = CH_CR;
				ph_nx   = PH_LF;
			end
			PH_LF: begin
				byte_nx = CH_LF;
				last_nx = 1'b1;
				ph_nx   = PH_IDLE;
			end
			default: begin
				ph_nx = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_IDLE;
			out_valid <= 1'b0;
			idx_q     <= 3'd0;
			sum_q     <= 8'd0;
			first_q   <= 1'b0;
		end else if (start) begin
			ph_q    <= desc.has ? PH_COLON : PH_STAT;
			idx_q   <= 3'd0;
			sum_q   <= 8'd0;
			first_q <= 1'b1;
		end else if (ld) begin
			ph_q      <= ph_nx;
			out_valid <= 1'b1;
			first_q   <= 1'b0;
			if (ph_q == PH_BODY) begin
				// accumulate the checksum of the body, one byte a word
				idx_q <= idx_q + 3'd1;
				sum_q <= sum_q + byte_nx;
			end
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= desc;
			led_q <= led;
		end
		if (ld) begin
			has_byte       <= d_q.has;
			tx_byte        <= byte_nx;
			last_byte      <= last_nx;
			stagger_slots  <= first_q ? d_q.stagger : 8'd0;
			led_level      <= led_q;
			led_flash      <= last_nx & d_q.flash;
			valve_request  <= last_nx ? d_q.valve : VALVE_NONE;
			store_request  <= last_nx & d_q.store;
			stored_address <= last_nx ? d_q.store_addr : 8'd0;
		end
	end

endmodule

`default_nettype wire
